### design/grp_pkg.sv
// grp_pkg: types, constants and helpers shared by the grid rectangle packer
// no dependencies
`default_nettype none

package grp_pkg;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam int MAX_RECTS = 256;

  localparam int COL_W    = $clog2(GRID_COLS);
  localparam int ROW_W    = $clog2(GRID_ROWS);
  localparam int CELL_AW  = ROW_W + COL_W;
  localparam int CELLS    = GRID_COLS * GRID_ROWS;
  localparam int OWNER_AW = $clog2(MAX_RECTS);
  localparam int OWNER_W  = OWNER_AW + 1;
  localparam int OWNX_W   = 6;
  localparam int OWNW_W   = 7;
  localparam int OWN_DW   = OWNX_W + OWNW_W;

  localparam int CFG_W  = 13;
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_ATLAS_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ATLAS_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CELL_SHIFT   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BORDER       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ROW_STEP     = 3'd4;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
  } req_t;

  typedef struct packed {
    logic        placed;
    logic [12:0] pos_x;
    logic [12:0] pos_y;
  } rsp_t;

  typedef enum logic [1:0] {
    SEL_CLR,
    SEL_YX,
    SEL_LOW,
    SEL_RC
  } cell_sel_t;

  typedef struct packed {
    logic      start;
    logic      clr_step;
    logic      clr_owners;
    logic      set_failed;
    logic      y_init;
    logic      row_init;
    logic      x_edge;
    logic      run_init;
    logic      run_inc;
    logic      skip_clr;
    logic      hit_init;
    logic      hit_next;
    logic      y_adv;
    cell_sel_t cell_sel;
    logic      own_wr;
    logic      fill_wr;
    logic      owner_inc;
    logic      out_load;
    logic      out_ok;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic is_clear;
    logic failed;
    logic full;
    logic y_ok;
    logic x_ok;
    logic cell_nz;
    logic skip;
    logic run_more;
    logic run_full;
    logic hit_empty;
    logic hit_last;
  } sts_t;

  // pad by twice the border and round up to whole cells
  function automatic logic [12:0] cells_of(input logic [11:0] pix, input logic [7:0] border,
                                           input logic [2:0] cs);
    logic [13:0] p;
    logic [13:0] s;
    p = {2'b0, pix} + {5'b0, border, 1'b0};
    s = p + ((14'd1 << cs) - 14'd1);
    return 13'(s >> cs);
  endfunction

endpackage

`default_nettype wire

### design/grid_rectangle_packer.sv
// Grid rectangle packer: first-fit placement of rectangles on a 64 x 64 cell
// occupancy grid. After reset and after every clear transaction the grid memory
// is swept once, during which no request is taken. Unless a place request has
// failed since the last clear or the owner table is full, a place request
// reads grid cells one at a time in its search (one read port on the grid
// memory), jumps past each blocking rectangle, and then fills its cells one
// by one. Each spot tried reads its own cell, the free run on its lowest row
// while no full run has been found on the row yet, and up to its whole
// window. The next request is taken while a result still waits on the output.
// depends on grp_pkg, grp_ctrl, grp_datapath
`default_nettype none

module grid_rectangle_packer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [grp_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [grp_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire grp_pkg::req_t               req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output grp_pkg::rsp_t                    rsp
);
  import grp_pkg::*;

  ctl_t ctl;
  sts_t sts;

  grp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  grp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### design/grp_ram.sv
// grp_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module grp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### design/grp_datapath.sv
// grp_datapath: configuration registers, search counters, grid and owner memories
// depends on grp_pkg and grp_ram
`default_nettype none

module grp_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [grp_pkg::CFG_AW-1:0]  cfg_index,
  input  wire logic [grp_pkg::CFG_W-1:0]   cfg_data,
  input  wire grp_pkg::req_t               req,
  input  wire grp_pkg::ctl_t               ctl,
  output grp_pkg::sts_t                    sts,
  output grp_pkg::rsp_t                    rsp
);
  import grp_pkg::*;

  logic [12:0] atlas_width, atlas_height;
  logic [2:0]  cell_shift;
  logic [7:0]  border;
  logic [6:0]  row_step;

  logic [12:0] rw, rh;
  logic        is_clear;
  logic [13:0] x, y, run, r, c;
  logic        skip;
  logic [CELL_AW-1:0] clr_addr;
  logic [OWNER_W-1:0] next_owner;
  logic        failed;

  logic [12:0] cols_raw, rows_raw;
  logic [6:0]  cols, rows;
  logic [12:0] step;
  logic [6:0]  rs;
  logic [14:0] lower, xrun;
  logic [OWNER_W-1:0] id;
  logic        cell_we;
  logic [CELL_AW-1:0] cell_addr;
  logic [OWNER_W-1:0] cell_wdata, cell_rdata;
  logic [OWNER_AW-1:0] own_addr;
  logic [OWNER_W-1:0]  own_idx;
  logic [OWN_DW-1:0]   own_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= 13'd4096;
      atlas_height <= 13'd4096;
      cell_shift   <= 3'd6;
      border       <= 8'd0;
      row_step     <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
        REG_ATLAS_HEIGHT: atlas_height <= cfg_data;
        REG_CELL_SHIFT:   cell_shift   <= cfg_data[2:0];
        REG_BORDER:       border       <= cfg_data[7:0];
        REG_ROW_STEP:     row_step     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_raw = atlas_width >> cell_shift;
    rows_raw = atlas_height >> cell_shift;
    cols = (cols_raw > 13'(GRID_COLS)) ? 7'(GRID_COLS) : cols_raw[6:0];
    rows = (rows_raw > 13'(GRID_ROWS)) ? 7'(GRID_ROWS) : rows_raw[6:0];
    rs   = (row_step == 7'd0) ? 7'd1 : row_step;
    step = (rs > 7'd1 && rh > {6'b0, rs}) ? rh : {6'b0, rs};
    lower = (rh != 13'd0) ? ({1'b0, y} + {2'b0, rh} - 15'd1) : {1'b0, y};
    xrun  = {1'b0, x} + {1'b0, run};
    id    = next_owner + OWNER_W'(1);
  end

  always_comb begin
    sts.clr_last  = (clr_addr == CELL_AW'(CELLS - 1));
    sts.is_clear  = is_clear;
    sts.failed    = failed;
    sts.full      = (next_owner >= OWNER_W'(MAX_RECTS));
    sts.y_ok      = ({1'b0, y} + {2'b0, rh}) < {8'b0, rows};
    sts.x_ok      = ({1'b0, x} + {2'b0, rw}) < {8'b0, cols};
    sts.cell_nz   = (cell_rdata != '0);
    sts.skip      = skip;
    sts.run_more  = (xrun < {8'b0, cols}) && (run < {1'b0, rw});
    sts.run_full  = (run >= {1'b0, rw});
    sts.hit_empty = (rw == 13'd0) || (rh == 13'd0);
    sts.hit_last  = ({1'b0, r} + 15'd1 == {1'b0, y} + {2'b0, rh})
                 && ({1'b0, c} + 15'd1 == {1'b0, x} + {2'b0, rw});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      next_owner <= '0;
      failed     <= 1'b0;
    end else begin
      if (ctl.clr_step) begin
        clr_addr <= clr_addr + CELL_AW'(1);
      end
      if (ctl.clr_owners) begin
        next_owner <= '0;
        failed     <= 1'b0;
      end else if (ctl.owner_inc) begin
        next_owner <= id;
      end else if (ctl.set_failed) begin
        failed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      is_clear <= (req.command == CMD_CLEAR);
      rw <= cells_of(req.rect_width, border, cell_shift);
      rh <= cells_of(req.rect_height, border, cell_shift);
    end
    if (ctl.y_init) begin
      y <= '0;
    end else if (ctl.y_adv) begin
      y <= y + (skip ? ((rh != 13'd0) ? {1'b0, rh} : 14'd1) : {1'b0, step});
    end
    if (ctl.row_init) begin
      x    <= '0;
      skip <= 1'b1;
    end else begin
      if (ctl.x_edge) begin
        x <= 14'(own_rdata[OWN_DW-1:OWNW_W]) + 14'(own_rdata[OWNW_W-1:0]);
      end
      if (ctl.skip_clr) begin
        skip <= 1'b0;
      end
    end
    if (ctl.run_init) begin
      run <= '0;
    end else if (ctl.run_inc) begin
      run <= run + 14'd1;
    end
    if (ctl.hit_init) begin
      r <= y;
      c <= x;
    end else if (ctl.hit_next) begin
      if ({1'b0, c} + 15'd1 == {1'b0, x} + {2'b0, rw}) begin
        c <= x;
        r <= r + 14'd1;
      end else begin
        c <= c + 14'd1;
      end
    end
    if (ctl.out_load) begin
      rsp.placed <= ctl.out_ok;
      rsp.pos_x  <= ctl.out_ok ? (13'({7'b0, x[5:0]} << cell_shift) + 13'(border)) : 13'd0;
      rsp.pos_y  <= ctl.out_ok ? (13'({7'b0, y[5:0]} << cell_shift) + 13'(border)) : 13'd0;
    end
  end

  always_comb begin
    unique case (ctl.cell_sel)
      SEL_CLR: cell_addr = clr_addr;
      SEL_YX:  cell_addr = {y[ROW_W-1:0], x[COL_W-1:0]};
      SEL_LOW: cell_addr = {lower[ROW_W-1:0], xrun[COL_W-1:0]};
      SEL_RC:  cell_addr = {r[ROW_W-1:0], c[COL_W-1:0]};
      default: cell_addr = clr_addr;
    endcase
    cell_we    = ctl.clr_step || ctl.fill_wr;
    cell_wdata = ctl.fill_wr ? id : '0;
    own_idx    = cell_rdata - OWNER_W'(1);
    own_addr   = ctl.own_wr ? next_owner[OWNER_AW-1:0] : own_idx[OWNER_AW-1:0];
  end

  grp_ram #(.WIDTH(OWNER_W), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  grp_ram #(.WIDTH(OWN_DW), .DEPTH(MAX_RECTS)) u_owner_ram (
    .clk   (clk),
    .we    (ctl.own_wr),
    .addr  (own_addr),
    .wdata ({x[OWNX_W-1:0], rw[OWNW_W-1:0]}),
    .rdata (own_rdata)
  );

endmodule

`default_nettype wire

### design/grp_ctrl.sv
// grp_ctrl: sequencer for clearing, first-fit search and fill
// depends on grp_pkg
`default_nettype none

module grp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  input  wire grp_pkg::sts_t sts,
  output grp_pkg::ctl_t      ctl
);
  import grp_pkg::*;

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_DECIDE, S_CLR, S_YCHK, S_XCHK, S_XEV, S_XEDGE,
    S_RCHK, S_REV, S_HRD, S_HEV, S_OWN, S_FILL, S_RESULT
  } state_t;

  state_t state, state_next;
  logic   ok, ok_next;
  logic   take;

  assign req_stall = (state != S_IDLE);
  assign take = !rsp_valid || !rsp_stall;

  always_comb begin
    ctl        = '0;
    ctl.cell_sel = SEL_CLR;
    ctl.out_ok = ok;
    state_next = state;
    ok_next    = ok;
    unique case (state) inside
      S_BOOT, S_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = (state == S_BOOT) ? S_IDLE : S_RESULT;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.start  = 1'b1;
          ok_next    = 1'b0;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_clear) begin
          ctl.clr_owners = 1'b1;
          state_next = S_CLR;
        end else if (sts.failed) begin
          state_next = S_RESULT;
        end else if (sts.full) begin
          ctl.set_failed = 1'b1;
          state_next = S_RESULT;
        end else begin
          ctl.y_init = 1'b1;
          state_next = S_YCHK;
        end
      end
      S_YCHK: begin
        if (sts.y_ok) begin
          ctl.row_init = 1'b1;
          state_next = S_XCHK;
        end else begin
          ctl.set_failed = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_XCHK: begin
        ctl.cell_sel = SEL_YX;
        if (sts.x_ok) begin
          state_next = S_XEV;
        end else begin
          ctl.y_adv  = 1'b1;
          state_next = S_YCHK;
        end
      end
      S_XEV: begin
        if (sts.cell_nz) begin
          state_next = S_XEDGE;
        end else if (sts.skip) begin
          ctl.run_init = 1'b1;
          state_next = S_RCHK;
        end else begin
          ctl.hit_init = 1'b1;
          state_next = S_HRD;
        end
      end
      S_XEDGE: begin
        ctl.x_edge = 1'b1;
        state_next = S_XCHK;
      end
      S_RCHK: begin
        ctl.cell_sel = SEL_LOW;
        if (sts.run_more) begin
          state_next = S_REV;
        end else begin
          ctl.skip_clr = sts.run_full;
          ctl.hit_init = 1'b1;
          state_next = S_HRD;
        end
      end
      S_REV: begin
        if (sts.cell_nz) begin
          ctl.hit_init = 1'b1;
          state_next = S_HRD;
        end else begin
          ctl.run_inc = 1'b1;
          state_next = S_RCHK;
        end
      end
      S_HRD: begin
        ctl.cell_sel = SEL_RC;
        state_next = sts.hit_empty ? S_OWN : S_HEV;
      end
      S_HEV: begin
        if (sts.cell_nz) begin
          state_next = S_XEDGE;
        end else if (sts.hit_last) begin
          state_next = S_OWN;
        end else begin
          ctl.hit_next = 1'b1;
          state_next = S_HRD;
        end
      end
      S_OWN: begin
        ctl.own_wr   = 1'b1;
        ctl.hit_init = 1'b1;
        ok_next      = 1'b1;
        if (sts.hit_empty) begin
          ctl.owner_inc = 1'b1;
          state_next = S_RESULT;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        ctl.cell_sel = SEL_RC;
        ctl.fill_wr  = 1'b1;
        if (sts.hit_last) begin
          ctl.owner_inc = 1'b1;
          state_next = S_RESULT;
        end else begin
          ctl.hit_next = 1'b1;
        end
      end
      S_RESULT: begin
        if (take) begin
          ctl.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      ok        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      ok    <= ok_next;
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### test/tb_grid_rectangle_packer.sv
// tb_grid_rectangle_packer: self-checking testbench for the grid rectangle packer.
// A scoreboard class predicts every response from its own first-fit grid model.
// depends on grp_pkg and grid_rectangle_packer
`timescale 1ns / 100ps

module tb_grid_rectangle_packer;
  import grp_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int SWEEP_WAIT  = 4200;

  class pack_scoreboard;
    bit [8:0]    owner_of [GRID_ROWS*GRID_COLS];
    int unsigned own_x [MAX_RECTS];
    int unsigned own_w [MAX_RECTS];
    int unsigned next_owner;
    bit          failed;
    int unsigned aw, ah, cs, bd, rs;
    rsp_t        pending [$];
    int          errors;
    int          results;
    int          placements;

    function new();
      aw = 4096; ah = 4096; cs = 6; bd = 0; rs = 1;
      errors = 0; results = 0; placements = 0;
      foreach (own_x[i]) begin
        own_x[i] = 0;
        own_w[i] = 0;
      end
      wipe();
    endfunction

    function void wipe();
      foreach (owner_of[i]) owner_of[i] = '0;
      next_owner = 0;
      failed = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, int unsigned v);
      case (idx)
        REG_ATLAS_WIDTH:  aw = v & 'h1fff;
        REG_ATLAS_HEIGHT: ah = v & 'h1fff;
        REG_CELL_SHIFT:   cs = v & 'h7;
        REG_BORDER:       bd = v & 'hff;
        REG_ROW_STEP:     rs = v & 'h7f;
        default: ;
      endcase
    endfunction

    function int unsigned cell_at(int unsigned r, int unsigned c);
      if (r >= GRID_ROWS || c >= GRID_COLS) return 0;
      return int'(owner_of[r*GRID_COLS + c]);
    endfunction

    function int unsigned right_edge(int unsigned id);
      if (id == 0 || id > MAX_RECTS) return 0;
      return own_x[id-1] + own_w[id-1] - 1;
    endfunction

    function int unsigned first_hit(int unsigned x, int unsigned y, int unsigned w,
                                    int unsigned h);
      int unsigned id;
      for (int unsigned r = y; r < y + h; r++)
        for (int unsigned c = x; c < x + w; c++) begin
          id = cell_at(r, c);
          if (id != 0) return id;
        end
      return 0;
    endfunction

    function int unsigned to_cells(int unsigned pix);
      int unsigned p;
      p = pix + 2*bd;
      if (cs == 0) return p;
      return (p + (1 << cs) - 1) >> cs;
    endfunction

    function bit find_spot(int unsigned rw, int unsigned rh, output int unsigned px,
                           output int unsigned py);
      int unsigned cols, rows, step, x, y, id, lower, run;
      bit skip;
      px = 0; py = 0;
      cols = aw >> cs;
      rows = ah >> cs;
      step = (rs != 0) ? rs : 1;
      if (cols > GRID_COLS) cols = GRID_COLS;
      if (rows > GRID_ROWS) rows = GRID_ROWS;
      if (step > 1 && rh > step) step = rh;
      y = 0;
      while (y + rh < rows) begin
        skip = 1;
        lower = (rh != 0) ? y + rh - 1 : y;
        for (x = 0; x + rw < cols; x++) begin
          id = cell_at(y, x);
          if (id != 0) begin
            x = right_edge(id);
            continue;
          end
          if (skip) begin
            run = 0;
            while (run + x < cols && run < rw && cell_at(lower, x + run) == 0) run++;
            if (run >= rw) skip = 0;
          end
          id = first_hit(x, y, rw, rh);
          if (id != 0) begin
            x = right_edge(id);
            continue;
          end
          px = x;
          py = y;
          return 1;
        end
        y += skip ? ((rh != 0) ? rh : 1) : step;
      end
      return 0;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int unsigned rw, rh, x, y;
      e = '0;
      if (r.command == CMD_CLEAR) begin
        wipe();
      end else if (!failed) begin
        rw = to_cells(r.rect_width);
        rh = to_cells(r.rect_height);
        if (next_owner >= MAX_RECTS || !find_spot(rw, rh, x, y)) begin
          failed = 1;
        end else begin
          own_x[next_owner] = x;
          own_w[next_owner] = rw;
          next_owner++;
          for (int unsigned rr = y; rr < y + rh; rr++)
            for (int unsigned cc = x; cc < x + rw; cc++)
              if (rr < GRID_ROWS && cc < GRID_COLS)
                owner_of[rr*GRID_COLS + cc] = 9'(next_owner);
          e.placed = 1'b1;
          e.pos_x = 13'((x << cs) + bd);
          e.pos_y = 13'((y << cs) + bd);
          placements++;
        end
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: placed %0d x %0d y %0d",
                                   a.placed, a.pos_x, a.pos_y);
        return;
      end
      e = pending.pop_front();
      if (a.placed !== e.placed || a.pos_x !== e.pos_x || a.pos_y !== e.pos_y) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected placed %0d x %0d y %0d, got placed %0d x %0d y %0d",
                   e.placed, e.pos_x, e.pos_y, a.placed, a.pos_x, a.pos_y);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CFG_AW-1:0]  cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               req_valid;
  logic               req_stall;
  req_t               req;
  logic               rsp_valid;
  logic               rsp_stall;
  rsp_t               rsp;

  pack_scoreboard sb;
  int  cycles;
  bit  quiet;
  bit  long_start;
  int  long_left;
  int  burst_left;
  int  sent;
  int  reg_writes;

  grid_rectangle_packer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_rectangle_packer test failed");
      $finish;
    end
  end

  // response side: checks and random stall bursts
  initial begin
    rsp_stall = 1'b0;
    long_left = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if (long_left > 0) begin
        long_left--;
        rsp_stall <= 1'b1;
      end else if (long_start) begin
        long_start = 0;
        long_left = 400;
        rsp_stall <= 1'b1;
      end else if (quiet) begin
        rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 18);
        rsp_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send(logic cmd, int unsigned w, int unsigned h);
    req_t r;
    r.command = cmd;
    r.rect_width = w[11:0];
    r.rect_height = h[11:0];
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic set_reg(logic [CFG_AW-1:0] idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    sb.write_reg(idx, v);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned s, int unsigned b,
                           int unsigned st);
    set_reg(REG_ATLAS_WIDTH, w);
    set_reg(REG_ATLAS_HEIGHT, h);
    set_reg(REG_CELL_SHIFT, s);
    set_reg(REG_BORDER, b);
    set_reg(REG_ROW_STEP, st);
    cfg_we <= 1'b0;
  endtask

  // wait out all responses, then the clear sweep
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SWEEP_WAIT) @(posedge clk);
  endtask

  task automatic random_items(int n, int unsigned s);
    int unsigned w, h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send(CMD_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8 << s);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8 << s);
        if (w > 4095) w = 4095;
        if (h > 4095) h = 4095;
        send(CMD_PLACE, w, h);
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    quiet = 0;
    long_start = 0;
    sent = 0;
    reg_writes = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero size, single cell, full width failure, sticky failure
    send(CMD_PLACE, 0, 0);
    send(CMD_PLACE, 1, 1);
    send(CMD_PLACE, 64, 64);
    send(CMD_PLACE, 65, 1);
    send(CMD_PLACE, 4095, 4095);
    send(CMD_PLACE, 1, 1);
    send(CMD_CLEAR, 0, 0);
    send(CMD_PLACE, 4032, 64);
    send(CMD_PLACE, 64, 4032);
    send(CMD_PLACE, 64, 64);
    drain();
    configure(4096, 4096, 6, 255, 64);
    send(CMD_PLACE, 0, 0);
    send(CMD_PLACE, 100, 0);
    send(CMD_PLACE, 0, 100);
    send(CMD_PLACE, 10, 10);
    drain();
    configure(4096, 4096, 6, 0, 0);
    send(CMD_PLACE, 200, 130);
    send(CMD_PLACE, 64, 64);
    send(CMD_CLEAR, 4095, 4095);
    drain();

    configure(4096, 4096, 6, 0, 1);
    send(CMD_CLEAR, 0, 0);
    drain();

    random_items(25, 6);
    drain();
    configure(512, 512, 4, $urandom_range(0, 8), $urandom_range(0, 4));
    long_start = 1;
    random_items(25, 4);
    drain();
    configure(40, 40, 0, $urandom_range(0, 2), 0);
    send(CMD_CLEAR, 0, 0);
    random_items(25, 0);
    drain();
    configure(1000, 300, 5, 255, 64);
    send(CMD_CLEAR, 0, 0);
    random_items(20, 5);
    drain();
    configure(0, 4096, 6, 0, 1);
    send(CMD_CLEAR, 0, 0);
    random_items(4, 6);
    drain();
    configure(4096, 0, 6, 0, 1);
    random_items(4, 6);
    drain();
    configure(4096, 4096, 3, 1, 2);
    send(CMD_CLEAR, 0, 0);
    quiet = 1;
    random_items(20, 3);
    drain();

    $display("sent %0d transactions, checked %0d responses, %0d placed", sent, sb.results,
             sb.placements);
    $display("covered %0d register writes over grid sizes, shifts, borders and row steps",
             reg_writes);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("grid_rectangle_packer test passed");
    end else begin
      $display("grid_rectangle_packer test failed");
    end
    $finish;
  end

endmodule

### sim.f
design/grp_pkg.sv
design/grp_ram.sv
design/grp_datapath.sv
design/grp_ctrl.sv
design/grid_rectangle_packer.sv
test/tb_grid_rectangle_packer.sv
